// ===== sv/sct_pkg.sv =====
package sct_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int SHOWN_BITS     = 16;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_SQ   = 3'd2,
        MODE_DQ   = 3'd3,
        MODE_LT   = 3'd4,
        MODE_GT   = 3'd5
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_WORD    = 3'd0,
        KIND_SQUOTE  = 3'd1,
        KIND_DQUOTE  = 3'd2,
        KIND_PIPE    = 3'd3,
        KIND_IN      = 3'd4,
        KIND_OUT     = 3'd5,
        KIND_HEREDOC = 3'd6,
        KIND_APPEND  = 3'd7
    } token_kind_t;

    typedef enum logic [1:0] {
        QERR_NONE   = 2'd0,
        QERR_SINGLE = 2'd1,
        QERR_DOUBLE = 2'd2
    } quote_err_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef struct packed {
        logic                  is_summary;
        logic [7:0]            tok_byte;
        logic                  starts_token;
        token_kind_t           token_kind;
        logic [SHOWN_BITS-1:0] token_count;
        quote_err_t            quote_error;
    } result_t;

endpackage

// ===== sv/shell_command_tokenizer_unit.sv =====
// Shell command tokenizer.
// Input stream s_*: one command-line byte per transaction. s_tdata = ch,
// s_tuser = has_char (0 for an empty item), s_tlast = line_end.
// Output stream m_*: one result per transaction. m_tuser = is_summary,
// m_tlast = last result caused by the current input item, m_tdata packs
// tok_byte, starts_token, token_kind, token_count, quote_error.
// An accepted item waits in the input register until every result it
// causes has been loaded into the output register (an item that causes
// none is done at once); results pass through the output register. Plain
// word or quoted bytes run at one item per cycle while m_tready is high;
// an item that releases a held '<' or '>' or closes the line causes up to
// 3 results, which the single output register drains one per cycle.
// Reset returns the lexer to between-tokens with a zero token count and
// empties both registers. While m_tready is low the output register holds
// any result, and an item with results stays held while s_tready drops.
module shell_command_tokenizer_unit #(
    parameter int COUNT_BITS = sct_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] has_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] tok_byte, [8] starts_token,
                                   // [11:9] token_kind, [27:12] token_count,
                                   // [29:28] quote_error, [31:30] zero
    output logic        m_tuser,   // [0] is_summary
    output logic        m_tlast
);
    import sct_pkg::*;

    localparam int XW = COUNT_BITS + SHOWN_BITS;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_has_reg;
    logic       in_end_reg;
    logic [1:0] idx_reg;

    // lexer state
    lex_mode_t             mode_reg;
    logic [COUNT_BITS-1:0] tokens_reg;

    // output register
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    out_last_reg;

    // per-item evaluation
    result_t               res [0:3];
    logic [1:0]            n_res;
    lex_mode_t             mode_next;
    logic [COUNT_BITS-1:0] tokens_next;
    logic                  out_free;
    logic                  out_load;
    logic                  in_done;

    function automatic result_t mk_tok(logic [7:0] b, logic st, token_kind_t k);
        result_t r;
        r              = '0;
        r.tok_byte     = b;
        r.starts_token = st;
        r.token_kind   = k;
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] inc_sat(logic [COUNT_BITS-1:0] v, logic st);
        if (st && (v != '1))
            return v + COUNT_BITS'(1);
        return v;
    endfunction

    always_comb
    begin
        lex_mode_t             m;
        logic [COUNT_BITS-1:0] cnt;
        logic [1:0]            n;
        logic                  do_lex;
        logic [XW-1:0]         ext;
        quote_err_t            qerr;
        result_t               sr;

        m      = mode_reg;
        cnt    = tokens_reg;
        n      = 2'd0;
        do_lex = 1'b0;
        qerr   = QERR_NONE;
        sr     = '0;
        ext    = '0;
        for (int i = 0; i < 4; i++)
            res[i] = '0;

        if (in_has_reg)
        begin
            unique case (m)
                MODE_SQ, MODE_DQ:
                begin
                    res[n] = mk_tok(in_ch_reg, 1'b0,
                                    (m == MODE_SQ) ? KIND_SQUOTE : KIND_DQUOTE);
                    n = n + 2'd1;
                    if (in_ch_reg == ((m == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE))
                        m = MODE_IDLE;
                end
                MODE_LT, MODE_GT:
                begin
                    if (in_ch_reg == ((m == MODE_LT) ? CH_LT : CH_GT))
                    begin
                        res[n] = mk_tok(in_ch_reg, 1'b1,
                                        (m == MODE_LT) ? KIND_HEREDOC : KIND_APPEND);
                        cnt = inc_sat(cnt, 1'b1);
                        n = n + 2'd1;
                        res[n] = mk_tok(in_ch_reg, 1'b0,
                                        (m == MODE_LT) ? KIND_HEREDOC : KIND_APPEND);
                        n = n + 2'd1;
                        m = MODE_IDLE;
                    end
                    else
                    begin
                        res[n] = mk_tok((m == MODE_LT) ? CH_LT : CH_GT, 1'b1,
                                        (m == MODE_LT) ? KIND_IN : KIND_OUT);
                        cnt = inc_sat(cnt, 1'b1);
                        n = n + 2'd1;
                        m = MODE_IDLE;
                        do_lex = 1'b1;
                    end
                end
                default:
                    do_lex = 1'b1;
            endcase
        end

        if (do_lex)
        begin
            priority if (in_ch_reg == CH_SPACE)
                m = MODE_IDLE;
            else if (in_ch_reg == CH_SQUOTE)
            begin
                res[n] = mk_tok(in_ch_reg, 1'b1, KIND_SQUOTE);
                cnt = inc_sat(cnt, 1'b1);
                n = n + 2'd1;
                m = MODE_SQ;
            end
            else if (in_ch_reg == CH_DQUOTE)
            begin
                res[n] = mk_tok(in_ch_reg, 1'b1, KIND_DQUOTE);
                cnt = inc_sat(cnt, 1'b1);
                n = n + 2'd1;
                m = MODE_DQ;
            end
            else if (in_ch_reg == CH_PIPE)
            begin
                res[n] = mk_tok(in_ch_reg, 1'b1, KIND_PIPE);
                cnt = inc_sat(cnt, 1'b1);
                n = n + 2'd1;
                m = MODE_IDLE;
            end
            else if (in_ch_reg == CH_LT)
                m = MODE_LT;
            else if (in_ch_reg == CH_GT)
                m = MODE_GT;
            else if (m == MODE_WORD)
            begin
                res[n] = mk_tok(in_ch_reg, 1'b0, KIND_WORD);
                n = n + 2'd1;
            end
            else
            begin
                res[n] = mk_tok(in_ch_reg, 1'b1, KIND_WORD);
                cnt = inc_sat(cnt, 1'b1);
                n = n + 2'd1;
                m = MODE_WORD;
            end
        end

        if (in_end_reg)
        begin
            unique case (m)
                MODE_LT:
                begin
                    res[n] = mk_tok(CH_LT, 1'b1, KIND_IN);
                    cnt = inc_sat(cnt, 1'b1);
                    n = n + 2'd1;
                end
                MODE_GT:
                begin
                    res[n] = mk_tok(CH_GT, 1'b1, KIND_OUT);
                    cnt = inc_sat(cnt, 1'b1);
                    n = n + 2'd1;
                end
                MODE_SQ: qerr = QERR_SINGLE;
                MODE_DQ: qerr = QERR_DOUBLE;
                default: qerr = QERR_NONE;
            endcase
            ext            = XW'(cnt);
            sr.is_summary  = 1'b1;
            sr.token_count = (ext > XW'({SHOWN_BITS{1'b1}})) ? {SHOWN_BITS{1'b1}}
                                                             : ext[SHOWN_BITS-1:0];
            sr.quote_error = qerr;
            res[n] = sr;
            n = n + 2'd1;
            m   = MODE_IDLE;
            cnt = '0;
        end

        n_res       = n;
        mode_next   = m;
        tokens_next = cnt;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = in_valid_reg && (n_res != 2'd0) && out_free;
    assign in_done  = in_valid_reg &&
                      ((n_res == 2'd0) || (out_load && (idx_reg == n_res - 2'd1)));
    assign s_tready = !in_valid_reg || in_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            idx_reg       <= 2'd0;
            mode_reg      <= MODE_IDLE;
            tokens_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (in_done)
            begin
                idx_reg    <= 2'd0;
                mode_reg   <= mode_next;
                tokens_reg <= tokens_next;
            end
            else if (out_load)
                idx_reg <= idx_reg + 2'd1;

            if (out_free)
                out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg  <= s_tdata;
            in_has_reg <= s_tuser;
            in_end_reg <= s_tlast;
        end
        if (out_load)
        begin
            out_res_reg  <= res[idx_reg];
            out_last_reg <= (idx_reg == n_res - 2'd1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.is_summary;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.quote_error,
                       out_res_reg.token_count,
                       out_res_reg.token_kind,
                       out_res_reg.starts_token,
                       out_res_reg.tok_byte};

endmodule
